/* hw/rtl/sfla_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants
// Widths, status codes, the unit header record and the size class function
// for the segregated free list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int NUM_UNITS     = 2048;
  localparam int IDX_W         = $clog2(NUM_UNITS);
  localparam int SZ_W          = IDX_W + 1;
  localparam int TAG_W         = 16;
  localparam int REQ_W         = 16;
  localparam int SMALL_CLASSES = 5;
  localparam int NUM_LISTS     = SMALL_CLASSES + 1;
  localparam int CLS_W         = $clog2(NUM_LISTS);
  localparam int UNIT_SHIFT    = 5;
  localparam int HDR_BYTES     = 8;
  localparam int POOL_RESET    = 1536;
  localparam int POOL_MIN      = 3;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SZ_W-1:0]  sz_t;
  typedef logic [CLS_W-1:0] cls_t;

  typedef struct packed {
    logic              busy;
    logic [TAG_W-1:0]  tag;
    sz_t               size;
    sz_t               psize;
    idx_t              nxt;
    idx_t              prv;
  } entry_t;

  typedef struct packed {
    idx_t   addr;
    entry_t data;
    logic   busy_en;
    logic   tag_en;
    logic   size_en;
    logic   psize_en;
    logic   nxt_en;
    logic   prv_en;
  } mem_wr_t;

  function automatic cls_t class_of(input sz_t sz);
    cls_t c;
    if (sz >= SZ_W'(1) && sz <= SZ_W'(SMALL_CLASSES)) begin
      c = CLS_W'(sz - SZ_W'(1));
    end else begin
      c = CLS_W'(SMALL_CLASSES);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sfla_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_mem: unit header store
// One header per unit, one read and one write port. Each field has its own
// write enable; read data is registered.
// ----------------------------------------------------------------------------
module sfla_mem
  import sfla_pkg::*;
(
  input  wire logic    clk,
  input  wire idx_t    rd_addr,
  output entry_t       rd_data,
  input  wire mem_wr_t wr
);

  logic             busy_mem  [NUM_UNITS];
  logic [TAG_W-1:0] tag_mem   [NUM_UNITS];
  sz_t              size_mem  [NUM_UNITS];
  sz_t              psize_mem [NUM_UNITS];
  idx_t             nxt_mem   [NUM_UNITS];
  idx_t             prv_mem   [NUM_UNITS];

  always_ff @(posedge clk) begin
    if (wr.busy_en)  busy_mem[wr.addr]  <= wr.data.busy;
    if (wr.tag_en)   tag_mem[wr.addr]   <= wr.data.tag;
    if (wr.size_en)  size_mem[wr.addr]  <= wr.data.size;
    if (wr.psize_en) psize_mem[wr.addr] <= wr.data.psize;
    if (wr.nxt_en)   nxt_mem[wr.addr]   <= wr.data.nxt;
    if (wr.prv_en)   prv_mem[wr.addr]   <= wr.data.prv;
  end

  always_ff @(posedge clk) begin
    rd_data.busy  <= busy_mem[rd_addr];
    rd_data.tag   <= tag_mem[rd_addr];
    rd_data.size  <= size_mem[rd_addr];
    rd_data.psize <= psize_mem[rd_addr];
    rd_data.nxt   <= nxt_mem[rd_addr];
    rd_data.prv   <= prv_mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hw/rtl/segregated_free_list_allocator_unit.sv */
`default_nettype none
// Throughput: one item at a time; the header store's single read and write
//   port serialize every list walk, unlink, split and merge step.
// Reset and any pool_units write start a clearing pass over all NUM_UNITS
//   headers, then set up the free block and sentinels, before the first item is taken.
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_unit: boundary tag pool allocator
// Sequencer over the unit header store with five small LIFO class lists
// and one first-fit large list; splits on alloc, coalesces on free.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_unit
  import sfla_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [SZ_W-1:0]  cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_func,
  input  wire logic [REQ_W-1:0] in_req_bytes,
  input  wire logic [TAG_W-1:0] in_alloc_tag,
  input  wire logic [IDX_W-1:0] in_buffer_index,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_status,
  output logic [IDX_W-1:0]      out_block_index,
  output logic [SZ_W-1:0]       out_block_units
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_INIT0  = 5'd1;
  localparam logic [4:0] S_INIT1  = 5'd2;
  localparam logic [4:0] S_INITL  = 5'd3;
  localparam logic [4:0] S_IDLE   = 5'd4;
  localparam logic [4:0] S_A_RD   = 5'd5;
  localparam logic [4:0] S_WALK   = 5'd6;
  localparam logic [4:0] S_RM1    = 5'd7;
  localparam logic [4:0] S_RM2    = 5'd8;
  localparam logic [4:0] S_A_SPL  = 5'd9;
  localparam logic [4:0] S_A_SPL2 = 5'd10;
  localparam logic [4:0] S_A_SPL3 = 5'd11;
  localparam logic [4:0] S_A_FIN  = 5'd12;
  localparam logic [4:0] S_F_RD   = 5'd13;
  localparam logic [4:0] S_F_P    = 5'd14;
  localparam logic [4:0] S_F_NRD  = 5'd15;
  localparam logic [4:0] S_F_N    = 5'd16;
  localparam logic [4:0] S_F_FIN  = 5'd17;
  localparam logic [4:0] S_F_INS  = 5'd18;
  localparam logic [4:0] S_F_INS2 = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  logic [4:0]       state_r, state_nxt;
  logic [4:0]       ret_r, ret_nxt;
  sz_t              pool_r, pool_nxt;
  idx_t             clr_r, clr_nxt;
  sz_t              need_r, need_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  idx_t             bi_r, bi_nxt;
  idx_t             e_r, e_nxt;
  idx_t             h_r, h_nxt;
  sz_t              blk_r, blk_nxt;
  sz_t              esz_r, esz_nxt;
  entry_t           ent_r, ent_nxt;
  idx_t             head_r   [NUM_LISTS];
  idx_t             head_nxt [NUM_LISTS];
  logic [1:0]       res_st_r, res_st_nxt;
  idx_t             res_idx_r, res_idx_nxt;
  sz_t              res_units_r, res_units_nxt;
  logic             out_valid_r;

  idx_t    rd_addr;
  entry_t  rd_data;
  mem_wr_t wr;

  logic [REQ_W:0] need_sum;
  sz_t            need_in;
  cls_t           need_cls;
  logic           small_hit;
  idx_t           small_pick;
  sz_t            cfg_clamp;
  logic           in_acc;
  logic           out_load;
  sz_t            left_sz;
  cls_t           ins_cls;

  sfla_mem u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  assign need_sum = {1'b0, in_req_bytes} + (REQ_W+1)'(HDR_BYTES + (1 << UNIT_SHIFT) - 1);
  assign need_in  = SZ_W'(need_sum >> UNIT_SHIFT);
  assign need_cls = class_of(need_in);
  assign left_sz  = ent_r.size - need_r;

  always_comb begin
    if (cfg_wdata < SZ_W'(POOL_MIN)) begin
      cfg_clamp = SZ_W'(POOL_MIN);
    end else if (cfg_wdata > SZ_W'(NUM_UNITS)) begin
      cfg_clamp = SZ_W'(NUM_UNITS);
    end else begin
      cfg_clamp = cfg_wdata;
    end
  end

  // first non-empty class at or above the request size
  always_comb begin
    small_hit  = 1'b0;
    small_pick = '0;
    for (int c = 0; c < NUM_LISTS; c++) begin
      if (!small_hit && CLS_W'(c) >= need_cls && head_r[c] != '0) begin
        small_hit  = 1'b1;
        small_pick = head_r[c];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    pool_nxt      = pool_r;
    clr_nxt       = clr_r;
    need_nxt      = need_r;
    tag_nxt       = tag_r;
    bi_nxt        = bi_r;
    e_nxt         = e_r;
    h_nxt         = h_r;
    blk_nxt       = blk_r;
    esz_nxt       = esz_r;
    ent_nxt       = ent_r;
    head_nxt      = head_r;
    res_st_nxt    = res_st_r;
    res_idx_nxt   = res_idx_r;
    res_units_nxt = res_units_r;
    rd_addr       = e_r;
    wr            = '0;
    ins_cls       = '0;

    case (state_r)
      S_CLR: begin
        wr.addr     = clr_r;
        wr.busy_en  = 1'b1;
        wr.size_en  = 1'b1;
        wr.psize_en = 1'b1;
        clr_nxt     = clr_r + IDX_W'(1);
        if (clr_r == '1) state_nxt = S_INIT0;
      end
      S_INIT0: begin
        wr.addr      = '0;
        wr.data.busy = 1'b1;
        wr.data.size = SZ_W'(1);
        wr.busy_en   = 1'b1;
        wr.size_en   = 1'b1;
        state_nxt    = S_INIT1;
      end
      S_INIT1: begin
        wr.addr       = IDX_W'(1);
        wr.data.size  = pool_r - SZ_W'(2);
        wr.data.psize = SZ_W'(1);
        wr.size_en    = 1'b1;
        wr.psize_en   = 1'b1;
        wr.nxt_en     = 1'b1;
        wr.prv_en     = 1'b1;
        for (int c = 0; c < NUM_LISTS; c++) head_nxt[c] = '0;
        head_nxt[class_of(pool_r - SZ_W'(2))] = IDX_W'(1);
        state_nxt = S_INITL;
      end
      S_INITL: begin
        wr.addr       = IDX_W'(pool_r - SZ_W'(1));
        wr.data.busy  = 1'b1;
        wr.data.size  = SZ_W'(1);
        wr.data.psize = pool_r - SZ_W'(2);
        wr.busy_en    = 1'b1;
        wr.size_en    = 1'b1;
        wr.psize_en   = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          need_nxt = need_in;
          tag_nxt  = in_alloc_tag;
          bi_nxt   = in_buffer_index;
          if (in_func == FUNC_ALLOC) begin
            if (need_in <= SZ_W'(SMALL_CLASSES)) begin
              e_nxt   = small_pick;
              rd_addr = small_pick;
              if (small_hit) begin
                state_nxt = S_A_RD;
              end else begin
                res_st_nxt = ST_OOM;
                state_nxt  = S_OUT;
              end
            end else begin
              e_nxt   = head_r[SMALL_CLASSES];
              rd_addr = head_r[SMALL_CLASSES];
              if (head_r[SMALL_CLASSES] != '0) begin
                state_nxt = S_WALK;
              end else begin
                res_st_nxt = ST_OOM;
                state_nxt  = S_OUT;
              end
            end
            res_idx_nxt   = '0;
            res_units_nxt = '0;
          end else begin
            rd_addr       = in_buffer_index;
            res_st_nxt    = ST_IGNORED;
            res_idx_nxt   = '0;
            res_units_nxt = '0;
            if (in_buffer_index != '0 &&
                ({1'b0, in_buffer_index} + SZ_W'(1)) < pool_r) begin
              state_nxt = S_F_RD;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_A_RD: begin
        ent_nxt   = rd_data;
        ret_nxt   = (rd_data.size > need_r) ? S_A_SPL : S_A_FIN;
        state_nxt = S_RM1;
      end
      S_WALK: begin
        if (need_r <= rd_data.size) begin
          ent_nxt   = rd_data;
          ret_nxt   = (rd_data.size > need_r) ? S_A_SPL : S_A_FIN;
          state_nxt = S_RM1;
        end else if (rd_data.nxt == '0) begin
          res_st_nxt = ST_OOM;
          state_nxt  = S_OUT;
        end else begin
          e_nxt   = rd_data.nxt;
          rd_addr = rd_data.nxt;
        end
      end
      // unlink the block held in ent_r
      S_RM1: begin
        if (ent_r.prv == '0) begin
          head_nxt[class_of(ent_r.size)] = ent_r.nxt;
        end else begin
          wr.addr     = ent_r.prv;
          wr.data.nxt = ent_r.nxt;
          wr.nxt_en   = 1'b1;
        end
        state_nxt = S_RM2;
      end
      S_RM2: begin
        if (ent_r.nxt != '0) begin
          wr.addr     = ent_r.nxt;
          wr.data.prv = ent_r.prv;
          wr.prv_en   = 1'b1;
        end
        state_nxt = ret_r;
      end
      S_A_SPL: begin
        ins_cls       = class_of(left_sz);
        wr.addr       = e_r + need_r[IDX_W-1:0];
        wr.data.tag   = ent_r.tag;
        wr.data.size  = left_sz;
        wr.data.psize = need_r;
        wr.data.nxt   = head_r[ins_cls];
        wr.busy_en    = 1'b1;
        wr.tag_en     = 1'b1;
        wr.size_en    = 1'b1;
        wr.psize_en   = 1'b1;
        wr.nxt_en     = 1'b1;
        wr.prv_en     = 1'b1;
        h_nxt         = head_r[ins_cls];
        head_nxt[ins_cls] = e_r + need_r[IDX_W-1:0];
        state_nxt     = S_A_SPL2;
      end
      S_A_SPL2: begin
        if (h_r != '0) begin
          wr.addr     = h_r;
          wr.data.prv = e_r + need_r[IDX_W-1:0];
          wr.prv_en   = 1'b1;
        end
        state_nxt = S_A_SPL3;
      end
      S_A_SPL3: begin
        wr.addr       = e_r + ent_r.size[IDX_W-1:0];
        wr.data.psize = left_sz;
        wr.psize_en   = 1'b1;
        state_nxt     = S_A_FIN;
      end
      S_A_FIN: begin
        wr.addr      = e_r;
        wr.data.busy = 1'b1;
        wr.data.tag  = tag_r;
        wr.data.size = (ent_r.size > need_r) ? need_r : ent_r.size;
        wr.busy_en   = 1'b1;
        wr.tag_en    = 1'b1;
        wr.size_en   = 1'b1;
        res_st_nxt    = ST_ALLOC;
        res_idx_nxt   = e_r;
        res_units_nxt = wr.data.size;
        state_nxt     = S_OUT;
      end
      S_F_RD: begin
        if (!rd_data.busy) begin
          state_nxt = S_OUT;
        end else begin
          blk_nxt    = rd_data.size;
          wr.addr    = bi_r;
          wr.busy_en = 1'b1;
          e_nxt      = bi_r - rd_data.psize[IDX_W-1:0];
          rd_addr    = bi_r - rd_data.psize[IDX_W-1:0];
          state_nxt  = S_F_P;
        end
      end
      S_F_P: begin
        if (!rd_data.busy) begin
          ent_nxt   = rd_data;
          esz_nxt   = rd_data.size + blk_r;
          ret_nxt   = S_F_NRD;
          state_nxt = S_RM1;
        end else begin
          e_nxt     = bi_r;
          esz_nxt   = blk_r;
          state_nxt = S_F_NRD;
        end
      end
      S_F_NRD: begin
        rd_addr   = e_r + esz_r[IDX_W-1:0];
        state_nxt = S_F_N;
      end
      S_F_N: begin
        if (!rd_data.busy) begin
          ent_nxt   = rd_data;
          esz_nxt   = esz_r + rd_data.size;
          ret_nxt   = S_F_FIN;
          state_nxt = S_RM1;
        end else begin
          state_nxt = S_F_FIN;
        end
      end
      S_F_FIN: begin
        if (esz_r != blk_r) begin
          wr.addr       = e_r + esz_r[IDX_W-1:0];
          wr.data.psize = esz_r;
          wr.psize_en   = 1'b1;
        end
        state_nxt = S_F_INS;
      end
      S_F_INS: begin
        ins_cls      = class_of(esz_r);
        wr.addr      = e_r;
        wr.data.size = esz_r;
        wr.data.nxt  = head_r[ins_cls];
        wr.size_en   = 1'b1;
        wr.nxt_en    = 1'b1;
        wr.prv_en    = 1'b1;
        h_nxt        = head_r[ins_cls];
        head_nxt[ins_cls] = e_r;
        state_nxt    = S_F_INS2;
      end
      S_F_INS2: begin
        if (h_r != '0) begin
          wr.addr     = h_r;
          wr.data.prv = e_r;
          wr.prv_en   = 1'b1;
        end
        res_st_nxt    = ST_FREED;
        res_idx_nxt   = e_r;
        res_units_nxt = esz_r;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLR;
        clr_nxt   = '0;
      end
    endcase

    // a pool size write restarts initialization
    if (cfg_we) begin
      pool_nxt  = cfg_clamp;
      clr_nxt   = '0;
      state_nxt = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pool_r      <= SZ_W'(POOL_RESET);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_LISTS; c++) head_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      pool_r  <= pool_nxt;
      clr_r   <= clr_nxt;
      head_r  <= head_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r       <= ret_nxt;
    need_r      <= need_nxt;
    tag_r       <= tag_nxt;
    bi_r        <= bi_nxt;
    e_r         <= e_nxt;
    h_r         <= h_nxt;
    blk_r       <= blk_nxt;
    esz_r       <= esz_nxt;
    ent_r       <= ent_nxt;
    res_st_r    <= res_st_nxt;
    res_idx_r   <= res_idx_nxt;
    res_units_r <= res_units_nxt;
    if (out_load) begin
      out_status      <= res_st_r;
      out_block_index <= res_idx_r;
      out_block_units <= res_units_r;
    end
  end

  assign out_valid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after item accepted");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result presented without sequencer completion");

  a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OOM || out_status == ST_IGNORED))
      |-> (out_block_index == '0 && out_block_units == '0))
    else $error("failed result carries nonzero block");

  a_pool_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pool_r >= SZ_W'(POOL_MIN)) && (pool_r <= SZ_W'(NUM_UNITS)))
    else $error("pool size out of range");

endmodule
`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: segregated free list allocator unit
// Drives allocate and free items against a behavioral pool of boundary-tag
// blocks kept in the bench, and checks every result in order. Covers
// request and handle extremes, sentinels, merges and several pool sizes
// under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench
  import sfla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0] status;
    idx_t       index;
    sz_t        units;
  } grant_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [SZ_W-1:0]  cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_func = 1'b0;
  logic [REQ_W-1:0] in_req_bytes = '0;
  logic [TAG_W-1:0] in_alloc_tag = '0;
  logic [IDX_W-1:0] in_buffer_index = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_block_index;
  logic [SZ_W-1:0]  out_block_units;

  segregated_free_list_allocator_unit i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_req_bytes(in_req_bytes), .in_alloc_tag(in_alloc_tag),
    .in_buffer_index(in_buffer_index), .out_valid(out_valid),
    .out_stall(out_stall), .out_status(out_status),
    .out_block_index(out_block_index), .out_block_units(out_block_units)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pool shadow
  int unsigned pool_n;
  bit          blk_busy[NUM_UNITS];
  bit [15:0]   blk_tag[NUM_UNITS];
  bit [11:0]   blk_size[NUM_UNITS];
  bit [11:0]   blk_psize[NUM_UNITS];
  bit [11:0]   blk_next[NUM_UNITS];
  bit [11:0]   blk_prev[NUM_UNITS];
  bit [11:0]   free_head[NUM_LISTS];

  grant_t      pending_grants[$];
  int unsigned live_blocks[$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned size_class(int unsigned sz);
    if (sz >= 1 && sz <= SMALL_CLASSES) return sz - 1;
    return SMALL_CLASSES;
  endfunction

  function automatic void link_block(int unsigned e);
    int unsigned c, n;
    c = size_class(blk_size[e]);
    n = free_head[c];
    blk_next[e] = n;
    blk_prev[e] = 0;
    if (n != 0) blk_prev[n] = e;
    free_head[c] = e;
  endfunction

  function automatic void unlink_block(int unsigned e);
    int unsigned p, n;
    p = blk_prev[e];
    n = blk_next[e];
    if (p == 0) free_head[size_class(blk_size[e])] = n;
    else blk_next[p] = n;
    if (n != 0) blk_prev[n] = p;
  endfunction

  function automatic void pool_reset(int unsigned v);
    int unsigned u;
    u = v & 12'hfff;
    if (u < POOL_MIN) u = POOL_MIN;
    if (u > NUM_UNITS) u = NUM_UNITS;
    pool_n = u;
    for (int i = 0; i < NUM_UNITS; i++) begin
      blk_busy[i] = 0; blk_tag[i] = 0; blk_size[i] = 0;
      blk_psize[i] = 0; blk_next[i] = 0; blk_prev[i] = 0;
    end
    for (int i = 0; i < NUM_LISTS; i++) free_head[i] = 0;
    blk_busy[0] = 1;
    blk_size[0] = 1;
    blk_size[1] = u - 2;
    blk_psize[1] = 1;
    link_block(1);
    blk_busy[u-1] = 1;
    blk_size[u-1] = 1;
    blk_psize[u-1] = u - 2;
    live_blocks.delete();
  endfunction

  function automatic grant_t pool_step(bit func, int unsigned req, int unsigned tag,
                                       int unsigned bi);
    grant_t g;
    int unsigned need, e, cur, steps, have, left, nx, blk, p, n;
    g = '{status: ST_IGNORED, index: '0, units: '0};
    e = 0;
    if (func == FUNC_ALLOC) begin
      need = (req + HDR_BYTES + (1 << UNIT_SHIFT) - 1) >> UNIT_SHIFT;
      if (need <= SMALL_CLASSES) begin
        for (int c = size_class(need); c <= SMALL_CLASSES; c++) begin
          if (free_head[c] != 0) begin
            e = free_head[c];
            break;
          end
        end
      end else begin
        cur = free_head[SMALL_CLASSES];
        steps = 0;
        while (cur != 0 && steps < NUM_UNITS) begin
          if (need <= blk_size[cur]) begin
            e = cur;
            break;
          end
          cur = blk_next[cur];
          steps++;
        end
      end
      if (e == 0) begin
        g.status = ST_OOM;
      end else begin
        have = blk_size[e];
        unlink_block(e);
        if (have > need) begin
          left = have - need;
          nx = (e + need) % NUM_UNITS;
          blk_size[e] = need;
          blk_size[nx] = left;
          blk_psize[nx] = need;
          blk_tag[nx] = blk_tag[e];
          blk_busy[nx] = 0;
          link_block(nx);
          blk_psize[(nx + left) % NUM_UNITS] = left;
        end
        blk_busy[e] = 1;
        blk_tag[e] = tag;
        g = '{status: ST_ALLOC, index: idx_t'(e), units: sz_t'(blk_size[e])};
      end
    end else if (bi != 0 && bi + 1 < pool_n && blk_busy[bi]) begin
      e = bi;
      blk = blk_size[e];
      blk_busy[e] = 0;
      p = (e + NUM_UNITS - blk_psize[e]) % NUM_UNITS;
      if (!blk_busy[p]) begin
        unlink_block(p);
        blk_size[p] = blk_size[p] + blk;
        e = p;
      end
      n = (e + blk_size[e]) % NUM_UNITS;
      if (!blk_busy[n]) begin
        unlink_block(n);
        blk_size[e] = blk_size[e] + blk_size[n];
      end
      if (blk_size[e] != blk) blk_psize[(e + blk_size[e]) % NUM_UNITS] = blk_size[e];
      link_block(e);
      g = '{status: ST_FREED, index: idx_t'(e), units: sz_t'(blk_size[e])};
    end
    return g;
  endfunction

  // One item; valid stays high on return so a following item goes back to back.
  task automatic send_item(bit func, int unsigned req, int unsigned tag,
                           int unsigned bi);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_req_bytes    <= REQ_W'(req);
    in_alloc_tag    <= TAG_W'(tag);
    in_buffer_index <= IDX_W'(bi);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = pool_step(func, req & 16'hffff, tag & 16'hffff, bi & 11'h7ff);
    pending_grants.push_back(g);
    if (g.status == ST_ALLOC) live_blocks.push_back(g.index);
    if (g.status == ST_FREED) begin
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == (bi & 11'h7ff)) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_units(int unsigned v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= SZ_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_reset(v);
  endtask

  task automatic free_live(int unsigned k);
    send_item(FUNC_FREE, $urandom(), $urandom(), live_blocks[k]);
  endtask

  task automatic test_directed();
    send_item(FUNC_ALLOC, 0, 16'h0000, 0);
    send_item(FUNC_ALLOC, 24, 16'hffff, 11'h7ff);
    send_item(FUNC_ALLOC, 25, 16'h1234, 0);
    send_item(FUNC_ALLOC, 152, 16'h8000, 0);
    send_item(FUNC_ALLOC, 153, 16'h0001, 0);
    send_item(FUNC_ALLOC, 65528, 16'h5a5a, 0);
    send_item(FUNC_ALLOC, 65535, 16'ha5a5, 0);
    // null, out of range, trailing sentinel, unit just below it
    send_item(FUNC_FREE, 16'hffff, 16'hffff, 0);
    send_item(FUNC_FREE, 0, 0, 11'h7ff);
    send_item(FUNC_FREE, 0, 0, 1535);
    send_item(FUNC_FREE, 0, 0, 1534);
    // free middle block, then its neighbors to merge both ways
    send_item(FUNC_FREE, 0, 0, 3);
    send_item(FUNC_FREE, 0, 0, 3);
    send_item(FUNC_FREE, 0, 0, 1);
    send_item(FUNC_FREE, 0, 0, 5);
    send_item(FUNC_FREE, 0, 0, 2);
    send_item(FUNC_ALLOC, 1000, 16'h00ff, 0);
    send_item(FUNC_FREE, 0, 0, 10);
    send_item(FUNC_FREE, 0, 0, 1);
  endtask

  task automatic test_pool_extremes();
    write_pool_units(0);
    send_item(FUNC_ALLOC, 0, 16'hbeef, 0);
    send_item(FUNC_ALLOC, 0, 16'hbeef, 0);
    send_item(FUNC_FREE, 0, 0, 1);
    send_item(FUNC_FREE, 0, 0, 1);
    write_pool_units(12'hfff);
    send_item(FUNC_ALLOC, 65528, 16'h0f0f, 0);
    send_item(FUNC_ALLOC, 2046 * 32 - 8, 16'hf0f0, 0);
    send_item(FUNC_ALLOC, 1, 16'h0000, 0);
    send_item(FUNC_FREE, 0, 0, 1);
    send_item(FUNC_FREE, 0, 0, 2047);
  endtask

  task automatic test_random(int unsigned pool, int n_items, int sidle, int ridle,
                             int max_req);
    int unsigned req;
    write_pool_units(pool);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 3) begin
        // hold until the block has nothing outstanding
        in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge clk);
      end
      if (live_blocks.size() == 0 || $urandom_range(99) < 55) begin
        case ($urandom_range(9))
          0: req = $urandom() & 16'hffff;
          1, 2: req = $urandom_range(max_req);
          default: req = $urandom_range(160);
        endcase
        send_item(FUNC_ALLOC, req, $urandom(), $urandom());
      end else if ($urandom_range(99) < 88) begin
        free_live($urandom_range(live_blocks.size() - 1));
      end else begin
        send_item(FUNC_FREE, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  always @(posedge clk) begin
    grant_t g;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $error("result with none outstanding: status %0d", out_status);
        mismatch_count++;
      end else begin
        g = pending_grants.pop_front();
        if (out_status !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, out_status);
          mismatch_count++;
        end
        if (out_block_index !== g.index) begin
          $error("block_index: expected %0d, got %0d", g.index, out_block_index);
          mismatch_count++;
        end
        if (out_block_units !== g.units) begin
          $error("block_units: expected %0d, got %0d", g.units, out_block_units);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    pool_reset(POOL_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pool_extremes();
    test_random(POOL_RESET, 320, 24, 78, 4000);
    test_random(40, 280, 78, 24, 1200);
    test_random(2048, 330, 0, 0, 8000);
    wait_drained();
    if (mismatch_count == 0 && pending_grants.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
